// ===== design/crgd_pkg.sv =====
// Shared types and constants for the column run-length glyph decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package crgd_pkg;

    // coordinate arithmetic width (wraps at this width)
    localparam int COORD_BITS = 10;
    // width of the coordinate fields on the ports
    localparam int PIX_BITS = 10;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

    // code byte values
    localparam logic [7:0] CODE_NEXT_COL = 8'h80;
    localparam logic [7:0] CODE_SKIP_MAX = 8'h8F;
    localparam int RUN_SHIFT = 4;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // one queued command: a run of pixels or a single status beat
    typedef struct packed {
        kind_t       kind;
        coord_t      x;
        coord_t      y;
        logic [3:0]  color;
        logic [2:0]  count;
    } cmd_t;

    // internal coordinate to port field
    function automatic logic [PIX_BITS-1:0] to_pix(input coord_t c);
        logic [31:0] wide;
        wide = 32'(c);
        return wide[PIX_BITS-1:0];
    endfunction

    // port field to internal coordinate
    function automatic coord_t from_pix(input logic [PIX_BITS-1:0] p);
        logic [31:0] wide;
        wide = 32'(p);
        return wide[COORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/crgd_front.sv =====
// Front end: accepts code bytes, tracks glyph position, emits at most one command per byte.
// Depends on crgd_pkg.
`default_nettype none

module crgd_front
    import crgd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        mono_mode,
    input  wire logic        accept,
    input  wire logic [7:0]  code_byte,
    input  wire logic        glyph_start,
    input  wire logic [PIX_BITS-1:0] origin_left,
    input  wire logic [PIX_BITS-1:0] origin_top,
    input  wire logic [7:0]  column_count,
    output logic             push,
    output cmd_t             push_cmd
);

    coord_t     cur_x_reg, cur_x_next;
    coord_t     cur_y_reg, cur_y_next;
    coord_t     top_row_reg, top_row_next;
    logic [7:0] cols_done_reg, cols_done_next;
    logic [7:0] cols_total_reg, cols_total_next;
    logic       halted_reg, halted_next;

    // byte decode and position update
    always_comb begin
        logic       skip_decode;
        logic [7:0] cols_inc;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        top_row_next    = top_row_reg;
        cols_done_next  = cols_done_reg;
        cols_total_next = cols_total_reg;
        halted_next     = halted_reg;
        push            = 1'b0;
        push_cmd        = '{kind: KIND_PIXEL, x: cur_x_reg, y: cur_y_reg,
                            color: 4'd0, count: 3'd1};
        skip_decode     = 1'b0;
        cols_inc        = 8'd0;

        if (accept) begin
            // glyph start reloads position
            if (glyph_start) begin
                cur_x_next      = from_pix(origin_left);
                top_row_next    = from_pix(origin_top);
                cur_y_next      = from_pix(origin_top);
                cols_done_next  = 8'd0;
                cols_total_next = column_count;
                halted_next     = 1'b0;
                if (column_count == 8'd0) begin
                    halted_next = 1'b1;
                    skip_decode = 1'b1;
                    push        = 1'b1;
                    push_cmd    = '{kind: KIND_DONE, x: cur_x_next, y: cur_y_next,
                                    color: 4'd0, count: 3'd1};
                end
            end

            if (!halted_next && !skip_decode) begin
                if (!code_byte[7]) begin
                    // run of pixels downward
                    push_cmd = '{kind: KIND_PIXEL, x: cur_x_next, y: cur_y_next,
                                 color: mono_mode ? 4'd0 : code_byte[3:0],
                                 count: code_byte[RUN_SHIFT+2:RUN_SHIFT]};
                    push       = (code_byte[RUN_SHIFT+2:RUN_SHIFT] != 3'd0);
                    cur_y_next = cur_y_next + {{(COORD_BITS-3){1'b0}},
                                               code_byte[RUN_SHIFT+2:RUN_SHIFT]};
                end else if (code_byte == CODE_NEXT_COL) begin
                    // next column, back to the top row
                    cols_inc       = cols_done_next + 8'd1;
                    cur_x_next     = cur_x_next + 1'b1;
                    cur_y_next     = top_row_next;
                    cols_done_next = cols_inc;
                    if (cols_inc == cols_total_next) begin
                        halted_next = 1'b1;
                        push        = 1'b1;
                        push_cmd    = '{kind: KIND_DONE, x: cur_x_next, y: cur_y_next,
                                        color: 4'd0, count: 3'd1};
                    end
                end else if (code_byte <= CODE_SKIP_MAX) begin
                    // skip rows
                    cur_y_next = cur_y_next + {{(COORD_BITS-4){1'b0}}, code_byte[3:0]};
                end else begin
                    // bad code
                    halted_next = 1'b1;
                    push        = 1'b1;
                    push_cmd    = '{kind: KIND_ERROR, x: cur_x_next, y: cur_y_next,
                                    color: 4'd0, count: 3'd1};
                end
            end
        end
    end

    // position state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            top_row_reg    <= '0;
            cols_done_reg  <= 8'd0;
            cols_total_reg <= 8'd0;
            halted_reg     <= 1'b1;
        end else begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            top_row_reg    <= top_row_next;
            cols_done_reg  <= cols_done_next;
            cols_total_reg <= cols_total_next;
            halted_reg     <= halted_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/crgd_queue.sv =====
// Short command queue between the front and back ends.
// Depends on crgd_pkg.
`default_nettype none

module crgd_queue
    import crgd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      empty,
    output cmd_t      head
);

    cmd_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;

    assign full  = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/crgd_back.sv =====
// Back end: expands queued commands into result beats, one per cycle while m_ready is high.
// Depends on crgd_pkg.
`default_nettype none

module crgd_back
    import crgd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_empty,
    input  wire cmd_t q_head,
    output logic      q_pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output logic [1:0]          m_kind,
    output logic [PIX_BITS-1:0] m_pixel_x,
    output logic [PIX_BITS-1:0] m_pixel_y,
    output logic [3:0]          m_pixel_color,
    output logic                m_last
);

    logic       busy_reg;
    cmd_t       cmd_reg;
    logic       load;
    logic       beat_done;

    assign beat_done = busy_reg && m_ready;
    assign load      = !q_empty && (!busy_reg || (beat_done && cmd_reg.count == 3'd1));
    assign q_pop     = load;

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load) begin
            busy_reg <= 1'b1;
        end else if (beat_done && cmd_reg.count == 3'd1) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cmd_reg <= q_head;
        end else if (beat_done) begin
            cmd_reg.y     <= cmd_reg.y + 1'b1;
            cmd_reg.count <= cmd_reg.count - 3'd1;
        end
    end

    assign m_valid       = busy_reg;
    assign m_kind        = cmd_reg.kind;
    assign m_pixel_x     = to_pix(cmd_reg.x);
    assign m_pixel_y     = to_pix(cmd_reg.y);
    assign m_pixel_color = cmd_reg.color;
    assign m_last        = (cmd_reg.count == 3'd1);

endmodule

`default_nettype wire

// ===== design/column_rle_glyph_decoder_unit.sv =====
// Column run-length glyph decoder: code bytes in, pixel/done/error beats out.
// A byte's command goes to the command queue, then to the back end's command register,
// which drives the result beat. Throughput: one byte per cycle into the front while the
// 4-entry command queue has room; the back gives one beat per cycle while m_ready is high,
// so a run byte of n pixels (up to 7) gives n beats, and a full queue stalls the input.
// Reset: synchronous active-low aresetn; the block waits for a glyph start, mono off.
// Depends on crgd_pkg, crgd_front, crgd_queue, crgd_back.
`default_nettype none

module column_rle_glyph_decoder_unit
    import crgd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_code_byte,
    input  wire logic                s_glyph_start,
    input  wire logic [PIX_BITS-1:0] s_origin_left,
    input  wire logic [PIX_BITS-1:0] s_origin_top,
    input  wire logic [7:0]          s_column_count,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_kind,
    output logic [PIX_BITS-1:0]      m_pixel_x,
    output logic [PIX_BITS-1:0]      m_pixel_y,
    output logic [3:0]               m_pixel_color,
    output logic                     m_last
);

    logic mono_mode_reg;
    logic accept;
    logic push, pop, q_full, q_empty;
    cmd_t push_cmd, q_head;

    // mono mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mono_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            mono_mode_reg <= cfg_wdata;
        end
    end

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    crgd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .mono_mode    (mono_mode_reg),
        .accept       (accept),
        .code_byte    (s_code_byte),
        .glyph_start  (s_glyph_start),
        .origin_left  (s_origin_left),
        .origin_top   (s_origin_top),
        .column_count (s_column_count),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    crgd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    crgd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire
